### rtl/lmq_pkg.sv
// ----------------------------------------------------------------------------
// lmq_pkg
// Shared constants, codes and types of the Lamport mutual exclusion queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lmq_pkg;

    localparam int LMQ_MAX_NODES  = 16;
    localparam int LMQ_CLOCK_BITS = 32;

    localparam int LMQ_ID_W       = 4;
    localparam int LMQ_TOTAL_W    = 5;
    localparam int LMQ_TYPE_W     = 3;
    localparam int LMQ_SEND_W     = 2;
    localparam int LMQ_MSGCLK_W   = 32;
    localparam int LMQ_COUNT_W    = 5;
    localparam int LMQ_REPLY_W    = 4;
    localparam int LMQ_CFG_IDX_W  = 1;
    localparam int LMQ_CFG_DATA_W = 5;

    // Input item kinds.
    localparam logic [LMQ_TYPE_W-1:0] REQ_RECV_REQUEST  = 3'd0;
    localparam logic [LMQ_TYPE_W-1:0] REQ_RECV_REPLY    = 3'd1;
    localparam logic [LMQ_TYPE_W-1:0] REQ_RECV_RELEASE  = 3'd2;
    localparam logic [LMQ_TYPE_W-1:0] REQ_LOCAL_REQUEST = 3'd3;
    localparam logic [LMQ_TYPE_W-1:0] REQ_LOCAL_RELEASE = 3'd4;

    // Outgoing message kinds.
    localparam logic [LMQ_SEND_W-1:0] MSG_REQUEST = 2'd0;
    localparam logic [LMQ_SEND_W-1:0] MSG_REPLY   = 2'd1;
    localparam logic [LMQ_SEND_W-1:0] MSG_RELEASE = 2'd2;

    // Configuration register indexes.
    localparam logic [LMQ_CFG_IDX_W-1:0] REG_NODE_ID     = 1'd0;
    localparam logic [LMQ_CFG_IDX_W-1:0] REG_TOTAL_NODES = 1'd1;

    localparam logic [LMQ_REPLY_W-1:0] REPLY_MAX = 4'd15;

    // Queue operation handed to every cell.
    typedef struct packed {
        logic insert;
        logic remove;
    } lmq_cmd_t;

endpackage

`default_nettype wire

### rtl/lmq_cell.sv
// ----------------------------------------------------------------------------
// lmq_cell
// One slot of the sorted request queue. Compares the new key with its own
// entry and takes the new key, its left neighbor's entry or its right
// neighbor's entry as the queue operation demands.
// ----------------------------------------------------------------------------
`default_nettype none

module lmq_cell
    import lmq_pkg::*;
#(
    parameter int CLOCK_BITS = LMQ_CLOCK_BITS,
    parameter bit FIRST      = 1'b0
)
(
    input  wire                   clk,
    input  lmq_cmd_t              cmd,
    input  wire                   occupied,
    input  wire  [CLOCK_BITS-1:0] key_clock,
    input  wire  [LMQ_ID_W-1:0]   key_id,
    input  wire                   left_gt,
    input  wire  [CLOCK_BITS-1:0] left_clock,
    input  wire  [LMQ_ID_W-1:0]   left_id,
    input  wire  [CLOCK_BITS-1:0] right_clock,
    input  wire  [LMQ_ID_W-1:0]   right_id,
    output logic                  gt,
    output logic [CLOCK_BITS-1:0] ent_clock,
    output logic [LMQ_ID_W-1:0]   ent_id
);

    logic [CLOCK_BITS-1:0] clock_reg;
    logic [LMQ_ID_W-1:0]   id_reg;
    logic                  take_new;

    // The new key goes behind this entry only when strictly greater, so an
    // equal key lands in front of existing equals.
    assign gt = occupied && ((key_clock > clock_reg) ||
                             ((key_clock == clock_reg) && (key_id > id_reg)));

    assign take_new = !gt && (FIRST || left_gt);

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            if (take_new)
            begin
                clock_reg <= key_clock;
                id_reg    <= key_id;
            end
            else if (!gt)
            begin
                clock_reg <= left_clock;
                id_reg    <= left_id;
            end
        end
        else if (cmd.remove)
        begin
            clock_reg <= right_clock;
            id_reg    <= right_id;
        end
    end

    assign ent_clock = clock_reg;
    assign ent_id    = id_reg;

endmodule

`default_nettype wire

### rtl/lmq_chain.sv
// ----------------------------------------------------------------------------
// lmq_chain
// Row of queue cells kept sorted by (clock, node id); slot 0 is the head.
// ----------------------------------------------------------------------------
`default_nettype none

module lmq_chain
    import lmq_pkg::*;
#(
    parameter int MAX_NODES  = LMQ_MAX_NODES,
    parameter int CLOCK_BITS = LMQ_CLOCK_BITS,
    localparam int FW        = $clog2(MAX_NODES + 1)
)
(
    input  wire                   clk,
    input  lmq_cmd_t              cmd,
    input  wire  [FW-1:0]         fill,
    input  wire  [CLOCK_BITS-1:0] key_clock,
    input  wire  [LMQ_ID_W-1:0]   key_id,
    output logic [LMQ_ID_W-1:0]   head_next_id
);

    logic                  gt_a    [MAX_NODES];
    logic [CLOCK_BITS-1:0] clock_a [MAX_NODES];
    logic [LMQ_ID_W-1:0]   id_a    [MAX_NODES];

    genvar i;
    generate
        for (i = 0; i < MAX_NODES; i++)
        begin : g_cell
            logic                  lgt;
            logic [CLOCK_BITS-1:0] lclk;
            logic [LMQ_ID_W-1:0]   lid;
            logic [CLOCK_BITS-1:0] rclk;
            logic [LMQ_ID_W-1:0]   rid;

            if (i == 0)
            begin : g_left_edge
                assign lgt  = 1'b1;
                assign lclk = key_clock;
                assign lid  = key_id;
            end
            else
            begin : g_left
                assign lgt  = gt_a[i-1];
                assign lclk = clock_a[i-1];
                assign lid  = id_a[i-1];
            end

            if (i == MAX_NODES - 1)
            begin : g_right_edge
                assign rclk = clock_a[i];
                assign rid  = id_a[i];
            end
            else
            begin : g_right
                assign rclk = clock_a[i+1];
                assign rid  = id_a[i+1];
            end

            lmq_cell #(
                .CLOCK_BITS (CLOCK_BITS),
                .FIRST      (i == 0)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (FW'(i) < fill),
                .key_clock   (key_clock),
                .key_id      (key_id),
                .left_gt     (lgt),
                .left_clock  (lclk),
                .left_id     (lid),
                .right_clock (rclk),
                .right_id    (rid),
                .gt          (gt_a[i]),
                .ent_clock   (clock_a[i]),
                .ent_id      (id_a[i])
            );
        end
    endgenerate

    // Id that slot 0 will hold after the pending operation.
    always_comb
    begin
        if (cmd.insert)
            head_next_id = gt_a[0] ? id_a[0] : key_id;
        else if (cmd.remove)
            head_next_id = id_a[1];
        else
            head_next_id = id_a[0];
    end

endmodule

`default_nettype wire

### rtl/lamport_mutex_request_queue.sv
// ----------------------------------------------------------------------------
// lamport_mutex_request_queue
// One node of Lamport's distributed mutual exclusion: logical clock, request
// queue sorted by (clock, node id) in a row of cells, and a reply counter.
// ----------------------------------------------------------------------------
// The clock update is prepared in the accept cycle and registered with the item; the
// queue cells shift and the result beat is registered in the following execute cycle.
// A new item is taken only once the node is idle again, after the last one executes.
// A stalled result beat holds the execute cycle until the output is free.
// Reset clears the logical clock, queue fill and reply count, sets node_id
// to 0 and total_nodes to 2; queue slots hold no defined value until written.
// ----------------------------------------------------------------------------
`default_nettype none

module lamport_mutex_request_queue
    import lmq_pkg::*;
#(
    parameter int MAX_NODES  = LMQ_MAX_NODES,
    parameter int CLOCK_BITS = LMQ_CLOCK_BITS
)
(
    input  wire                       clk,
    input  wire                       rst_n,

    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire  [LMQ_CFG_IDX_W-1:0]  cfg_index,
    input  wire  [LMQ_CFG_DATA_W-1:0] cfg_data,

    input  wire                       in_valid,
    output logic                      in_stall,
    input  wire  [LMQ_TYPE_W-1:0]     req_type,
    input  wire  [LMQ_MSGCLK_W-1:0]   msg_clock,
    input  wire  [LMQ_ID_W-1:0]       sender_id,

    output logic                      out_valid,
    input  wire                       out_stall,
    output logic                      send_valid,
    output logic [LMQ_SEND_W-1:0]     send_type,
    output logic [LMQ_MSGCLK_W-1:0]   send_clock,
    output logic [LMQ_ID_W-1:0]       dest_id,
    output logic                      broadcast,
    output logic                      grant,
    output logic [LMQ_ID_W-1:0]       head_id,
    output logic [LMQ_COUNT_W-1:0]    queue_count,
    output logic                      error
);

    localparam int FW = $clog2(MAX_NODES + 1);
    localparam int CW = CLOCK_BITS;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                   state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;

    logic [LMQ_ID_W-1:0]    node_id_reg;
    logic [LMQ_TOTAL_W-1:0] total_reg;

    logic [CW-1:0]          clock_reg;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [LMQ_REPLY_W-1:0] reply_reg, reply_next;

    // Item captured at accept, with its clock work already done.
    logic [LMQ_TYPE_W-1:0]  type_reg;
    logic [LMQ_ID_W-1:0]    sender_reg;
    logic [CW-1:0]          key_clock_reg;
    logic [LMQ_ID_W-1:0]    key_id_reg;
    logic [CW-1:0]          clk_new_reg;

    logic                   in_fire, exec_fire;
    logic [CW-1:0]          m_clk, top_clk, base_clk, clk_new;
    logic                   is_merge;
    logic                   want_insert, want_remove, full, empty;
    lmq_cmd_t               cmd;
    logic [LMQ_ID_W-1:0]    head_next_id;
    logic [LMQ_TOTAL_W-1:0] needed;

    logic                   o_send_valid, o_broadcast, o_error, o_grant;
    logic [LMQ_SEND_W-1:0]  o_send_type;
    logic [LMQ_ID_W-1:0]    o_dest_id, o_head_id;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg == S_EXEC);
    assign in_fire   = in_valid && !in_stall;
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    // Accept cycle: clock merge and tick.
    assign m_clk    = CW'(msg_clock);
    assign top_clk  = (clock_reg > m_clk) ? clock_reg : m_clk;
    assign is_merge = (req_type == REQ_RECV_REQUEST) || (req_type == REQ_RECV_REPLY) ||
                      (req_type == REQ_RECV_RELEASE);
    assign base_clk = is_merge ? top_clk : clock_reg;

    always_comb
    begin
        case (req_type)
            REQ_RECV_REQUEST:  clk_new = base_clk + CW'(2);
            REQ_RECV_REPLY,
            REQ_RECV_RELEASE,
            REQ_LOCAL_REQUEST,
            REQ_LOCAL_RELEASE: clk_new = base_clk + CW'(1);
            default:           clk_new = clock_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            type_reg    <= req_type;
            sender_reg  <= sender_id;
            clk_new_reg <= clk_new;
            if (req_type == REQ_LOCAL_REQUEST)
            begin
                key_clock_reg <= clock_reg + CW'(1);
                key_id_reg    <= node_id_reg;
            end
            else
            begin
                key_clock_reg <= m_clk;
                key_id_reg    <= sender_id;
            end
        end
    end

    // Execute cycle: queue operation, counters and the result beat.
    assign full        = (fill_reg == FW'(MAX_NODES));
    assign empty       = (fill_reg == '0);
    assign want_insert = (type_reg == REQ_RECV_REQUEST) || (type_reg == REQ_LOCAL_REQUEST);
    assign want_remove = (type_reg == REQ_RECV_RELEASE) || (type_reg == REQ_LOCAL_RELEASE);

    assign cmd.insert = exec_fire && want_insert && !full;
    assign cmd.remove = exec_fire && want_remove && !empty;

    lmq_chain #(
        .MAX_NODES  (MAX_NODES),
        .CLOCK_BITS (CLOCK_BITS)
    ) u_chain (
        .clk          (clk),
        .cmd          (cmd),
        .fill         (fill_reg),
        .key_clock    (key_clock_reg),
        .key_id       (key_id_reg),
        .head_next_id (head_next_id)
    );

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.insert)
            fill_next = fill_reg + FW'(1);
        else if (cmd.remove)
            fill_next = fill_reg - FW'(1);
    end

    always_comb
    begin
        reply_next = reply_reg;
        if (type_reg == REQ_RECV_REPLY && reply_reg != REPLY_MAX)
            reply_next = reply_reg + LMQ_REPLY_W'(1);
        else if (type_reg == REQ_LOCAL_RELEASE)
            reply_next = '0;
    end

    assign needed = (total_reg == '0) ? '0 : total_reg - LMQ_TOTAL_W'(1);

    always_comb
    begin
        o_send_valid = 1'b0;
        o_send_type  = MSG_REQUEST;
        o_dest_id    = '0;
        o_broadcast  = 1'b0;
        o_error      = 1'b0;
        case (type_reg)
            REQ_RECV_REQUEST:
            begin
                o_send_valid = 1'b1;
                o_send_type  = MSG_REPLY;
                o_dest_id    = sender_reg;
                o_error      = full;
            end
            REQ_RECV_RELEASE:
            begin
                o_error = empty;
            end
            REQ_LOCAL_REQUEST:
            begin
                o_send_valid = 1'b1;
                o_send_type  = MSG_REQUEST;
                o_broadcast  = 1'b1;
                o_error      = full;
            end
            REQ_LOCAL_RELEASE:
            begin
                o_send_valid = 1'b1;
                o_send_type  = MSG_RELEASE;
                o_broadcast  = 1'b1;
                o_error      = empty;
            end
            default:
            begin
                o_send_valid = 1'b0;
            end
        endcase
    end

    assign o_head_id = (fill_next != '0) ? head_next_id : '0;
    assign o_grant   = (fill_next != '0) && (head_next_id == node_id_reg) &&
                       ({1'b0, reply_next} == needed);

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            send_valid  <= o_send_valid;
            send_type   <= o_send_type;
            send_clock  <= o_send_valid ? LMQ_MSGCLK_W'(clk_new_reg) : '0;
            dest_id     <= o_dest_id;
            broadcast   <= o_broadcast;
            grant       <= o_grant;
            head_id     <= o_head_id;
            queue_count <= LMQ_COUNT_W'(fill_next);
            error       <= o_error;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_EXEC;
            S_EXEC:  if (exec_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            clock_reg     <= '0;
            fill_reg      <= '0;
            reply_reg     <= '0;
            node_id_reg   <= '0;
            total_reg     <= LMQ_TOTAL_W'(2);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec_fire)
            begin
                clock_reg <= clk_new_reg;
                fill_reg  <= fill_next;
                reply_reg <= reply_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NODE_ID:     node_id_reg <= cfg_data[LMQ_ID_W-1:0];
                    REG_TOTAL_NODES: total_reg   <= cfg_data;
                    default:         total_reg   <= total_reg;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for one node of the Lamport mutual exclusion queue.
// A directed table covers empty releases, clock wrap, equal keys and unknown
// kinds. Random request/reply/release rounds, queue floods and noise follow,
// under several node settings. The first directed rows are checked against fixed
// results, every other result beat against an in-bench model of the node's clock, sorted queue and reply counter.
// ----------------------------------------------------------------------------

module tb;
    import lmq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                   send_valid;
        logic [LMQ_SEND_W-1:0]  send_type;
        logic [31:0]            send_clock;
        logic [LMQ_ID_W-1:0]    dest_id;
        logic                   broadcast;
        logic                   grant;
        logic [LMQ_ID_W-1:0]    head_id;
        logic [LMQ_COUNT_W-1:0] queue_count;
        logic                   error;
    } node_out_t;

    typedef struct packed {
        logic [LMQ_TYPE_W-1:0] kind;
        logic [31:0]           mclk;
        logic [LMQ_ID_W-1:0]   sender;
        logic                  fixed;
        node_out_t             res;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [LMQ_CFG_IDX_W-1:0]  cfg_index;
    logic [LMQ_CFG_DATA_W-1:0] cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [LMQ_TYPE_W-1:0]     req_type;
    logic [LMQ_MSGCLK_W-1:0]   msg_clock;
    logic [LMQ_ID_W-1:0]       sender_id;
    logic                      out_valid;
    logic                      out_stall;
    logic                      send_valid;
    logic [LMQ_SEND_W-1:0]     send_type;
    logic [LMQ_MSGCLK_W-1:0]   send_clock;
    logic [LMQ_ID_W-1:0]       dest_id;
    logic                      broadcast;
    logic                      grant;
    logic [LMQ_ID_W-1:0]       head_id;
    logic [LMQ_COUNT_W-1:0]    queue_count;
    logic                      error;

    lamport_mutex_request_queue i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .msg_clock   (msg_clock),
        .sender_id   (sender_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .send_valid  (send_valid),
        .send_type   (send_type),
        .send_clock  (send_clock),
        .dest_id     (dest_id),
        .broadcast   (broadcast),
        .grant       (grant),
        .head_id     (head_id),
        .queue_count (queue_count),
        .error       (error)
    );

    // Node model state.
    logic [31:0]          lclock;
    logic [31:0]          qclk [LMQ_MAX_NODES];
    logic [LMQ_ID_W-1:0]  qid  [LMQ_MAX_NODES];
    int                   qfill;
    logic [3:0]           replies;
    logic [LMQ_ID_W-1:0]  cfg_node;
    logic [4:0]           cfg_total;

    node_out_t  outbox [$];
    stim_row_t  rows [$];
    node_out_t  beat_res;
    logic       beat_fixed;
    int         faults;
    int         items_sent;
    int         cycles;
    int         stall_left;
    bit         idle_on;
    bit         quiet_tail;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clock_absorb(input logic [31:0] mclk);
        logic [31:0] top;
        top    = (lclock > mclk) ? lclock : mclk;
        lclock = top + 32'd1;
    endfunction

    function automatic bit queue_insert(input logic [31:0] c, input logic [LMQ_ID_W-1:0] id);
        int pos;
        pos = 0;
        if (qfill >= LMQ_MAX_NODES)
            return 1'b0;
        // A new entry goes ahead of any entry with an equal key.
        while (pos < qfill && (c > qclk[pos] || (c == qclk[pos] && id > qid[pos])))
            pos++;
        for (int i = qfill; i > pos; i--)
        begin
            qclk[i] = qclk[i-1];
            qid[i]  = qid[i-1];
        end
        qclk[pos] = c;
        qid[pos]  = id;
        qfill++;
        return 1'b1;
    endfunction

    function automatic bit queue_pop_head();
        if (qfill == 0)
            return 1'b0;
        for (int i = 1; i < qfill; i++)
        begin
            qclk[i-1] = qclk[i];
            qid[i-1]  = qid[i];
        end
        qfill--;
        return 1'b1;
    endfunction

    function automatic node_out_t node_advance(input logic [LMQ_TYPE_W-1:0] kind,
                                               input logic [31:0] mclk,
                                               input logic [LMQ_ID_W-1:0] sender);
        node_out_t r;
        logic [4:0] needed;
        r = '0;
        case (kind)
            REQ_RECV_REQUEST:
            begin
                clock_absorb(mclk);
                if (!queue_insert(mclk, sender))
                    r.error = 1'b1;
                lclock       = lclock + 32'd1;
                r.send_valid = 1'b1;
                r.send_type  = MSG_REPLY;
                r.send_clock = lclock;
                r.dest_id    = sender;
            end
            REQ_RECV_REPLY:
            begin
                clock_absorb(mclk);
                if (replies != REPLY_MAX)
                    replies = replies + 4'd1;
            end
            REQ_RECV_RELEASE:
            begin
                clock_absorb(mclk);
                if (!queue_pop_head())
                    r.error = 1'b1;
            end
            REQ_LOCAL_REQUEST:
            begin
                lclock       = lclock + 32'd1;
                r.send_valid = 1'b1;
                r.send_type  = MSG_REQUEST;
                r.send_clock = lclock;
                r.broadcast  = 1'b1;
                if (!queue_insert(lclock, cfg_node))
                    r.error = 1'b1;
            end
            REQ_LOCAL_RELEASE:
            begin
                if (!queue_pop_head())
                    r.error = 1'b1;
                lclock       = lclock + 32'd1;
                r.send_valid = 1'b1;
                r.send_type  = MSG_RELEASE;
                r.send_clock = lclock;
                r.broadcast  = 1'b1;
                replies      = 4'd0;
            end
            default:
            begin
            end
        endcase
        needed = (cfg_total == 5'd0) ? 5'd0 : cfg_total - 5'd1;
        if (qfill > 0)
        begin
            r.head_id = qid[0];
            if ({1'b0, replies} == needed && qid[0] == cfg_node)
                r.grant = 1'b1;
        end
        r.queue_count = qfill[4:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            faults++;
        end
    endtask

    // Results are checked before the input beat of the same edge is modeled.
    always @(posedge clk)
    begin
        node_out_t got;
        node_out_t want;
        node_out_t calc;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{send_valid, send_type, send_clock, dest_id, broadcast,
                        grant, head_id, queue_count, error};
                if (outbox.size() == 0)
                begin
                    $error("result beat arrived with no request pending");
                    faults++;
                end
                else
                begin
                    want = outbox.pop_front();
                    check_field("send_valid", want.send_valid, got.send_valid);
                    check_field("send_type", want.send_type, got.send_type);
                    check_field("send_clock", want.send_clock, got.send_clock);
                    check_field("dest_id", want.dest_id, got.dest_id);
                    check_field("broadcast", want.broadcast, got.broadcast);
                    check_field("grant", want.grant, got.grant);
                    check_field("head_id", want.head_id, got.head_id);
                    check_field("queue_count", want.queue_count, got.queue_count);
                    check_field("error", want.error, got.error);
                end
            end
            if (in_valid && !in_stall)
            begin
                calc = node_advance(req_type, msg_clock, sender_id);
                outbox.push_back(beat_fixed ? beat_res : calc);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver stalls come in bursts, and only while idle_on is set.
    always @(negedge clk)
    begin
        if (!idle_on)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    function automatic node_out_t fixed_out(input logic sv, input logic [1:0] st,
                                            input logic [31:0] sc, input logic [3:0] dst,
                                            input logic bc, input logic gr,
                                            input logic [3:0] hd, input logic [4:0] qc,
                                            input logic er);
        node_out_t r;
        r = '{sv, st, sc, dst, bc, gr, hd, qc, er};
        return r;
    endfunction

    function automatic void add_row(input logic [2:0] kind, input logic [31:0] mclk,
                                    input logic [3:0] sender, input logic fixed = 1'b0,
                                    input node_out_t res = '0);
        rows.push_back('{kind, mclk, sender, fixed, res});
    endfunction

    function automatic logic [31:0] pick_clock();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 3);
            3: return lclock - $urandom_range(0, 5);
            default: return lclock + $urandom_range(0, 6);
        endcase
    endfunction

    task automatic push_item(input logic [LMQ_TYPE_W-1:0] kind, input logic [31:0] mclk,
                             input logic [LMQ_ID_W-1:0] sender, input logic fixed = 1'b0,
                             input node_out_t res = '0);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        msg_clock  <= mclk;
        sender_id  <= sender;
        beat_fixed <= fixed;
        beat_res   <= res;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [LMQ_CFG_IDX_W-1:0] idx,
                             input logic [LMQ_CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_NODE_ID)
            cfg_node = data[3:0];
        else
            cfg_total = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sender holds off until every pending result beat has been taken.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outbox.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One full round: local request, the replies it needs (at times one more) with peer
    // requests mixed in, local release, then the peers release in turn.
    task automatic run_session();
        int need;
        int peers;
        need = (cfg_total == 5'd0) ? 0 : int'(cfg_total) - 1;
        if (need > 15)
            need = 15;
        if ($urandom_range(0, 4) == 0)
            need++;
        peers = 0;
        push_item(REQ_LOCAL_REQUEST, $urandom, 4'($urandom_range(0, 15)));
        repeat (need)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                push_item(REQ_RECV_REQUEST, pick_clock(), 4'($urandom_range(0, 15)));
                peers++;
            end
            push_item(REQ_RECV_REPLY, pick_clock(), 4'($urandom_range(0, 15)));
        end
        push_item(REQ_LOCAL_RELEASE, $urandom, 4'($urandom_range(0, 15)));
        repeat (peers)
            push_item(REQ_RECV_RELEASE, pick_clock(), 4'($urandom_range(0, 15)));
    endtask

    // Fills the queue to near or past its depth, then drains it past empty.
    task automatic run_flood();
        int n;
        n = $urandom_range(14, 18);
        repeat (n)
            push_item(REQ_RECV_REQUEST, pick_clock(), 4'($urandom_range(0, 15)));
        push_item(REQ_LOCAL_REQUEST, $urandom, 4'($urandom_range(0, 15)));
        repeat (n + 1)
            push_item(REQ_RECV_RELEASE, pick_clock(), 4'($urandom_range(0, 15)));
        push_item(REQ_LOCAL_RELEASE, $urandom, 4'($urandom_range(0, 15)));
    endtask

    task automatic run_noise();
        logic [LMQ_TYPE_W-1:0] kind;
        if ($urandom_range(0, 9) == 0)
            kind = 3'($urandom_range(5, 7));
        else
            kind = 3'($urandom_range(0, 4));
        push_item(kind, pick_clock(), 4'($urandom_range(0, 15)));
    endtask

    initial
    begin
        logic [LMQ_CFG_DATA_W-1:0] node_set  [7];
        logic [LMQ_CFG_DATA_W-1:0] total_set [7];
        int quota;
        int pick;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_NODE_ID;
        cfg_data   = '0;
        in_valid   = 1'b0;
        req_type   = REQ_RECV_REQUEST;
        msg_clock  = '0;
        sender_id  = '0;
        out_stall  = 1'b0;
        beat_fixed = 1'b0;
        beat_res   = '0;
        lclock     = '0;
        qfill      = 0;
        replies    = '0;
        cfg_node   = '0;
        cfg_total  = 5'd2;
        faults     = 0;
        items_sent = 0;
        cycles     = 0;
        stall_left = 0;
        idle_on    = 1'b1;
        quiet_tail = 1'b0;

        // Release on an empty queue, then a reply that wraps the clock to 0.
        add_row(REQ_LOCAL_RELEASE, 32'd0, 4'd0, 1'b1,
                fixed_out(1, MSG_RELEASE, 32'd1, 4'd0, 1, 0, 4'd0, 5'd0, 1));
        add_row(REQ_RECV_RELEASE, 32'd0, 4'd0, 1'b1,
                fixed_out(0, 2'd0, 32'd0, 4'd0, 0, 0, 4'd0, 5'd0, 1));
        add_row(REQ_RECV_REPLY, 32'hFFFF_FFFF, 4'd15, 1'b1,
                fixed_out(0, 2'd0, 32'd0, 4'd0, 0, 0, 4'd0, 5'd0, 0));
        add_row(REQ_LOCAL_REQUEST, 32'hFFFF_FFFF, 4'd15, 1'b1,
                fixed_out(1, MSG_REQUEST, 32'd1, 4'd0, 1, 1, 4'd0, 5'd1, 0));
        add_row(REQ_RECV_REQUEST, 32'd1, 4'd15, 1'b1,
                fixed_out(1, MSG_REPLY, 32'd3, 4'd15, 0, 1, 4'd0, 5'd2, 0));
        // Same key as the local entry, then a key that goes to the head.
        add_row(REQ_RECV_REQUEST, 32'd1, 4'd0);
        add_row(REQ_RECV_REQUEST, 32'd0, 4'd7);
        add_row(3'd5, 32'hFFFF_FFFF, 4'd15);
        add_row(3'd6, 32'h0000_0000, 4'd0);
        add_row(3'd7, 32'hA5A5_5A5A, 4'd10);
        add_row(REQ_RECV_RELEASE, 32'h8000_0000, 4'd3);
        add_row(REQ_RECV_REPLY, 32'hFFFF_FFFE, 4'd5);
        add_row(REQ_LOCAL_REQUEST, 32'd0, 4'd0);
        add_row(REQ_RECV_REQUEST, 32'hFFFF_FFFF, 4'd15);
        add_row(REQ_RECV_REQUEST, 32'h5555_5555, 4'd9);
        add_row(REQ_LOCAL_RELEASE, 32'd0, 4'd0);
        add_row(REQ_RECV_RELEASE, 32'h0000_0001, 4'd1);
        add_row(REQ_RECV_RELEASE, 32'h7FFF_FFFF, 4'd14);
        add_row(REQ_RECV_RELEASE, 32'hFFFF_FFFF, 4'd15);
        add_row(REQ_RECV_RELEASE, 32'd0, 4'd0);
        add_row(REQ_RECV_REQUEST, 32'd0, 4'd0);
        add_row(REQ_LOCAL_RELEASE, 32'hFFFF_FFFF, 4'd15);

        node_set  = '{5'd15, 5'h15, 5'd0, 5'd9, 5'd3, 5'h1C, 5'($urandom_range(0, 31))};
        total_set = '{5'd16, 5'd3, 5'd0, 5'd1, 5'd31, 5'd17, 5'd2};

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            push_item(rows[i].kind, rows[i].mclk, rows[i].sender, rows[i].fixed,
                      rows[i].res);
        settle();

        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(REG_NODE_ID, node_set[ph]);
            write_reg(REG_TOTAL_NODES, total_set[ph]);
            quiet_tail = (ph == 6);
            quota = items_sent + 70;
            while (items_sent < quota)
            begin
                idle_on = quiet_tail ? 1'b0 : ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 19);
                if (pick < 10)
                    run_session();
                else if (pick < 12)
                    run_flood();
                else if (pick == 12)
                    settle();
                else
                    run_noise();
            end
            settle();
        end

        repeat (10) @(posedge clk);
        if (faults == 0 && outbox.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
